[rtl/cri_pkg.sv]
// Shared types and constants for the colour ramp interpolator.
// Transaction structs, operation codes, controller/datapath command and status.
// No dependencies.
package cri_pkg;

  localparam int MAX_KNOBS_DEF = 16;
  localparam int POS_W         = 17;
  localparam int CH_W          = 8;
  localparam int LVL_W         = 9;
  localparam int RGBA_W        = 4 * CH_W;
  localparam int NUM_W         = CH_W + POS_W;    // c * span fits here
  localparam int DVD_W         = NUM_W + 1;       // 2*num + span
  localparam int N_CHAN        = 4;
  localparam int DIV_STEPS     = CH_W;            // quotient never exceeds 255

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] position;
    logic [CH_W-1:0]  knob_red;
    logic [CH_W-1:0]  knob_green;
    logic [CH_W-1:0]  knob_blue;
    logic [LVL_W-1:0] knob_level;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_alpha;
  } out_item_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_KNOB,
    EMIT_BLEND
  } emit_sel_t;

  typedef struct packed {
    logic      clear;     // empty the table
    logic      append;    // store a knob if order and room allow
    logic      q_start;   // latch query position, rewind scan
    logic      advance;   // step scan address, keep previous knob
    logic      span;      // form span and distances of the bracketing pair
    logic      mul;       // form one channel's dividend
    logic [1:0] chan;     // channel for mul
    logic      div;       // one restoring divide step on all channels
    emit_sel_t emit;      // load result register
  } cmd_t;

  typedef struct packed {
    logic count_zero;     // table empty
    logic hit;            // scanned knob at or beyond target
    logic eq;             // scanned knob exactly at target
    logic idx_zero;       // scanned knob is the first one
  } sts_t;

endpackage

[rtl/cri_ctrl.sv]
// Controller for the colour ramp interpolator: sequences scan, multiply and divide.
// Depends on cri_pkg.
module cri_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    op,
  input  cri_pkg::sts_t sts,
  output logic          busy,
  output cri_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_SPAN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r;
  logic       acc;

  assign acc  = start && !busy_r;
  assign busy = busy_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.emit  = cri_pkg::EMIT_NONE;
    cmd.chan  = cnt_r[1:0];
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority if (op == cri_pkg::OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (op == cri_pkg::OP_APPEND) begin
            cmd.append = 1'b1;
          end else if (op == cri_pkg::OP_QUERY) begin
            if (sts.count_zero) begin
              cmd.emit = cri_pkg::EMIT_ZERO;
            end else begin
              cmd.q_start = 1'b1;
              state_nxt   = S_PRIME;
            end
          end else begin
            // unused code: drop
          end
        end
      end
      S_PRIME: begin
        cmd.advance = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (sts.idx_zero || sts.eq) begin
            cmd.emit  = cri_pkg::EMIT_KNOB;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SPAN;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SPAN: begin
        cmd.span  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r[1:0] == 2'(cri_pkg::N_CHAN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(cri_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit  = cri_pkg::EMIT_BLEND;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

[rtl/cri_dpath.sv]
// Datapath for the colour ramp interpolator: knob store, scan compare,
// per-channel multiply and four-lane restoring divider. Depends on cri_pkg.
module cri_dpath #(
  parameter int MAX_KNOBS = cri_pkg::MAX_KNOBS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cri_pkg::in_item_t   in_item,
  input  cri_pkg::cmd_t       cmd,
  output cri_pkg::sts_t       sts,
  output logic                out_valid,
  output cri_pkg::out_item_t  out_item
);

  localparam int IDXW = (MAX_KNOBS > 1) ? $clog2(MAX_KNOBS) : 1;
  localparam int CNTW = $clog2(MAX_KNOBS + 1);
  localparam int POS_W = cri_pkg::POS_W;
  localparam int CH_W  = cri_pkg::CH_W;
  localparam int NUM_W = cri_pkg::NUM_W;
  localparam int DVD_W = cri_pkg::DVD_W;
  localparam int NCH   = cri_pkg::N_CHAN;

  // knob store
  logic [POS_W-1:0]           pos_mem  [MAX_KNOBS];
  logic [cri_pkg::RGBA_W-1:0] rgba_mem [MAX_KNOBS];

  logic [CNTW-1:0]            count_r;
  logic [POS_W-1:0]           last_pos_r;
  logic                       app_ok;
  logic [cri_pkg::RGBA_W-1:0] new_rgba;
  logic [CH_W-1:0]            alpha;

  logic [IDXW-1:0]            addr_r, rd_idx_r;
  logic [POS_W-1:0]           rd_pos_r, prev_pos_r;
  logic [cri_pkg::RGBA_W-1:0] rd_rgba_r, prev_rgba_r;
  logic [POS_W-1:0]           x_r, t_r;

  logic [POS_W-1:0]           span_r, dist_r, rest_r;
  logic [DVD_W-1:0]           dsr_r;
  logic [DVD_W-1:0]           rem_r [NCH];
  logic [CH_W-1:0]            q_r   [NCH];

  logic [CH_W-1:0]            c0, c1;
  logic [NUM_W-1:0]           num;
  logic [DVD_W-1:0]           dvd;

  logic                       out_valid_r;
  cri_pkg::out_item_t         out_item_r;

  assign alpha    = in_item.knob_level[8] ? 8'hFF : in_item.knob_level[7:0];
  assign new_rgba = {in_item.knob_red, in_item.knob_green, in_item.knob_blue, alpha};
  assign app_ok   = (count_r < CNTW'(MAX_KNOBS)) &&
                    ((count_r == '0) || (in_item.position >= last_pos_r));

  always_ff @(posedge clk) begin
    if (cmd.append && app_ok) begin
      pos_mem[count_r[IDXW-1:0]]  <= in_item.position;
      rgba_mem[count_r[IDXW-1:0]] <= new_rgba;
      last_pos_r                  <= in_item.position;
    end
    // read the next knob; hold the pair once the scan stops
    if (cmd.advance) begin
      rd_pos_r  <= pos_mem[addr_r];
      rd_rgba_r <= rgba_mem[addr_r];
      rd_idx_r  <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append && app_ok) begin
      count_r <= count_r + 1'b1;
    end
  end

  // scan: the target is the query position clipped to the last knob
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      x_r    <= in_item.position;
      t_r    <= (in_item.position < last_pos_r) ? in_item.position : last_pos_r;
      addr_r <= '0;
    end else if (cmd.advance) begin
      addr_r      <= addr_r + 1'b1;
      prev_pos_r  <= rd_pos_r;
      prev_rgba_r <= rd_rgba_r;
    end
  end

  assign sts.count_zero = (count_r == '0);
  assign sts.hit        = (rd_pos_r >= t_r);
  assign sts.eq         = (rd_pos_r == t_r);
  assign sts.idx_zero   = (rd_idx_r == '0);

  // channel select: red in the top byte, alpha in the bottom
  always_comb begin
    unique case (cmd.chan)
      2'd0: begin c0 = prev_rgba_r[31:24]; c1 = rd_rgba_r[31:24]; end
      2'd1: begin c0 = prev_rgba_r[23:16]; c1 = rd_rgba_r[23:16]; end
      2'd2: begin c0 = prev_rgba_r[15:8];  c1 = rd_rgba_r[15:8];  end
      default: begin c0 = prev_rgba_r[7:0]; c1 = rd_rgba_r[7:0];  end
    endcase
  end

  assign num = NUM_W'(c0) * rest_r + NUM_W'(c1) * dist_r;
  assign dvd = {num, 1'b0} + DVD_W'(span_r);

  always_ff @(posedge clk) begin
    if (cmd.span) begin
      span_r <= rd_pos_r - prev_pos_r;
      dist_r <= x_r - prev_pos_r;
      rest_r <= rd_pos_r - x_r;
      dsr_r  <= DVD_W'({rd_pos_r - prev_pos_r, 1'b0}) << (cri_pkg::DIV_STEPS - 1);
    end else if (cmd.div) begin
      dsr_r <= dsr_r >> 1;
    end
    if (cmd.mul) begin
      rem_r[cmd.chan] <= dvd;
    end else if (cmd.div) begin
      for (int i = 0; i < NCH; i++) begin
        if (rem_r[i] >= dsr_r) begin
          rem_r[i] <= rem_r[i] - dsr_r;
          q_r[i]   <= {q_r[i][CH_W-2:0], 1'b1};
        end else begin
          q_r[i]   <= {q_r[i][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  // result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != cri_pkg::EMIT_NONE);
    end
    unique case (cmd.emit)
      cri_pkg::EMIT_ZERO:  out_item_r <= '0;
      cri_pkg::EMIT_KNOB:  out_item_r <= rd_rgba_r;
      cri_pkg::EMIT_BLEND: out_item_r <= {q_r[0], q_r[1], q_r[2], q_r[3]};
      default:             out_item_r <= out_item_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/color_ramp_interpolator_unit.sv]
// Top level of the colour ramp interpolator: knob table with linear colour blend.
// Instantiates cri_ctrl and cri_dpath; depends on cri_pkg.
//
// A transaction is taken when start is high and busy is low. Clear and append
// finish in the accepting cycle and leave busy low, so they may follow each
// other every cycle; an append that would overflow the table or go below the
// last stored position is dropped. Every query produces exactly one result,
// shown on out_item for one cycle with out_valid high; the receiver cannot
// stall it and must take it then. A query on an empty table answers in the
// cycle after acceptance with busy staying low. Any other query raises busy,
// and the knob table is scanned one knob a cycle from the first knob
// through its single read port, so a query that lands on a knob (or outside
// the table) shows its result in the first cycle with busy low again. A
// query between two knobs then forms the span, runs the per-channel multiply
// (one channel a cycle) and the restoring divide (one quotient bit a cycle on
// all four channels), and then loads the result. Entries are held in a small
// memory without reset; only entries below the knob count are read.
module color_ramp_interpolator_unit #(
  parameter int MAX_KNOBS = cri_pkg::MAX_KNOBS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cri_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cri_pkg::out_item_t out_item
);

  cri_pkg::cmd_t cmd;
  cri_pkg::sts_t sts;

  // sequence the query: scan, span, multiply, divide, emit
  cri_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_item.operation),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // hold the knobs and do the arithmetic
  cri_dpath #(
    .MAX_KNOBS (MAX_KNOBS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[verif/tb_color_ramp_interpolator_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for color_ramp_interpolator_unit: a directed table, then random
// knob tables with queries, every colour checked against the value typed in its row
// or an in-bench copy of the ramp. Depends on cri_pkg and the RTL of the unit.
module tb_color_ramp_interpolator_unit;

  typedef cri_pkg::in_item_t  in_item_t;
  typedef cri_pkg::out_item_t out_item_t;

  localparam int         POS_W         = cri_pkg::POS_W;
  localparam int         CH_W          = cri_pkg::CH_W;
  localparam int         LVL_W         = cri_pkg::LVL_W;
  localparam int         MAX_KNOBS_DEF = cri_pkg::MAX_KNOBS_DEF;
  localparam logic [1:0] OP_CLEAR      = cri_pkg::OP_CLEAR;
  localparam logic [1:0] OP_APPEND     = cri_pkg::OP_APPEND;
  localparam logic [1:0] OP_QUERY      = cri_pkg::OP_QUERY;

  // Operation code left unused by the unit; it must be swallowed without a result.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int          TARGET_ITEMS  = 1600;
  localparam int          SETTLE_CYCLES = 40;    // outlasts the longest query and its result
  localparam int          DRAIN_LIMIT   = 2000;
  localparam int unsigned POS_MAX       = 131071;

  typedef struct {
    in_item_t  item;
    bit        fixed;   // expected colour typed in the row, not predicted
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Travel alongside in_item so the monitor knows whether the row carries its own answer.
  bit        pin_fixed;
  out_item_t pin_want;

  // Shadow knob table.
  logic [POS_W-1:0] knob_pos [MAX_KNOBS_DEF];
  out_item_t        knob_col [MAX_KNOBS_DEF];
  int unsigned      knob_cnt;

  out_item_t        colour_due [$];   // colours still owed by the unit, oldest first
  logic [POS_W-1:0] knob_marks [$];   // positions appended in the current random ramp
  int               mismatch_cnt;
  int               taken_cnt;        // transactions that clear, store or query
  bit               steady_run;       // when set, the sender does not idle

  color_ramp_interpolator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_channel(input string name, input logic [CH_W-1:0] got,
                               input logic [CH_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Blend one channel between two knobs, rounding half up with an exact division.
  function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] c0, input logic [CH_W-1:0] c1,
                                           input longint unsigned d,
                                           input longint unsigned span);
    longint unsigned num;
    longint unsigned q;
    num = c0 * (span - d) + c1 * d;
    q   = (2 * num + span) / (2 * span);
    return (q > 255) ? 8'hFF : q[CH_W-1:0];
  endfunction

  // Colour of the ramp at position x, as held in the shadow table.
  function automatic out_item_t colour_at(input logic [POS_W-1:0] x);
    int              n;
    int              k;
    longint unsigned span;
    longint unsigned d;
    out_item_t       a;
    out_item_t       b;
    n = knob_cnt;
    if (n == 0) return '0;
    if (x <= knob_pos[0]) return knob_col[0];
    // Above the table: the first knob sharing the last position wins.
    if (x >= knob_pos[n-1]) begin
      for (k = 0; k < n; k++)
        if (knob_pos[k] == knob_pos[n-1]) return knob_col[k];
    end
    for (k = 0; k + 1 < n; k++) begin
      if (x == knob_pos[k]) return knob_col[k];
      if (x > knob_pos[k] && x < knob_pos[k+1]) begin
        a    = knob_col[k];
        b    = knob_col[k+1];
        span = 64'(knob_pos[k+1]) - 64'(knob_pos[k]);
        d    = 64'(x) - 64'(knob_pos[k]);
        return out_item_t'{out_red:   blend(a.out_red,   b.out_red,   d, span),
                           out_green: blend(a.out_green, b.out_green, d, span),
                           out_blue:  blend(a.out_blue,  b.out_blue,  d, span),
                           out_alpha: blend(a.out_alpha, b.out_alpha, d, span)};
      end
      if (x == knob_pos[k+1]) return knob_col[k+1];
    end
    return '0;
  endfunction

  // Advance the shadow table by one accepted transaction.
  function automatic void table_step(input in_item_t it, output bit answers,
                                     output bit effective, output out_item_t colour);
    answers   = 1'b0;
    effective = 1'b0;
    colour    = '0;
    case (it.operation)
      OP_CLEAR: begin
        knob_cnt  = 0;
        effective = 1'b1;
      end
      OP_APPEND: begin
        // Drop the knob when the table is full or it would go below the last one.
        if (knob_cnt < MAX_KNOBS_DEF &&
            (knob_cnt == 0 || it.position >= knob_pos[knob_cnt-1])) begin
          knob_pos[knob_cnt] = it.position;
          knob_col[knob_cnt] = out_item_t'{out_red:   it.knob_red,
                                           out_green: it.knob_green,
                                           out_blue:  it.knob_blue,
                                           out_alpha: (it.knob_level > 255) ? 8'hFF
                                                                            : it.knob_level[7:0]};
          knob_cnt++;
          effective = 1'b1;
        end
      end
      OP_QUERY: begin
        answers   = 1'b1;
        effective = 1'b1;
        colour    = colour_at(it.position);
      end
      default: ;
    endcase
  endfunction

  // Check results and record accepted transactions on the rising edge. Every signal
  // read here was last changed at a falling edge or is still pre-edge.
  always @(posedge clk) begin : watch
    bit        answers;
    bit        effective;
    out_item_t colour;
    out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (colour_due.size() == 0) begin
          report_mismatch($sformatf("result %h with no query pending", out_item));
        end else begin
          want = colour_due.pop_front();
          check_channel("red",   out_item.out_red,   want.out_red);
          check_channel("green", out_item.out_green, want.out_green);
          check_channel("blue",  out_item.out_blue,  want.out_blue);
          check_channel("alpha", out_item.out_alpha, want.out_alpha);
        end
      end
      if (start && !busy) begin
        table_step(in_item, answers, effective, colour);
        if (effective) taken_cnt++;
        if (answers) colour_due.push_back(pin_fixed ? pin_want : colour);
      end
    end
  end

  // Idle length: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] op, input int unsigned pos);
    in_item_t it;
    it.operation  = op;
    it.position   = pos[POS_W-1:0];
    it.knob_red   = CH_W'($urandom_range(0, 255));
    it.knob_green = CH_W'($urandom_range(0, 255));
    it.knob_blue  = CH_W'($urandom_range(0, 255));
    it.knob_level = LVL_W'($urandom_range(0, 511));
    return it;
  endfunction

  // Query position aimed at the current ramp: on knobs, beside them, between, or outside.
  function automatic int unsigned pick_query();
    int          r;
    int unsigned p;
    r = $urandom_range(0, 9);
    if (knob_marks.size() == 0 || r == 0) return $urandom_range(0, POS_MAX);
    p = 32'(knob_marks[$urandom_range(0, knob_marks.size() - 1)]);
    if (r < 4) return p;
    if (r < 6) begin
      if ($urandom_range(0, 1)) return (p == POS_MAX) ? p : p + 1;
      return (p == 0) ? p : p - 1;
    end
    if (r < 9) return $urandom_range(knob_marks[0], knob_marks[$]);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 65536;
      default: return POS_MAX;
    endcase
  endfunction

  // Present one transaction at the falling edge and hold it until the unit takes it.
  task automatic send(input in_item_t it, input bit fixed = 1'b0,
                      input out_item_t want = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    in_item   <= it;
    pin_fixed <= fixed;
    pin_want  <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off the sender until every owed colour has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (colour_due.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    dir_row_t    rows [$];
    int unsigned pos;
    int          nk;
    int          nq;
    int          step_max;
    int          pick;
    int          j;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    pin_fixed  = 1'b0;
    pin_want   = '0;
    steady_run = 1'b0;

    // Directed table: empty, single knob, dropped append, equal positions, far end,
    // position above 256.0, clear, and adjacent knobs one step apart.
    rows.push_back('{in_item_t'{OP_QUERY,  17'd0,      8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd0, 8'd0, 8'd0, 8'd0}});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd65536,  8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd0, 8'd0, 8'd0, 8'd0}});
    rows.push_back('{in_item_t'{OP_SPARE,  17'h1FFFF,  8'hFF,  8'hFF,  8'hFF,  9'h1FF},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_APPEND, 17'd256,    8'd10,  8'd20,  8'd30,  9'd300},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd0,      8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd10, 8'd20, 8'd30, 8'd255}});
    rows.push_back('{in_item_t'{OP_QUERY,  17'h1FFFF,  8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd10, 8'd20, 8'd30, 8'd255}});
    rows.push_back('{in_item_t'{OP_APPEND, 17'd100,    8'd1,   8'd2,   8'd3,   9'd4},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd100,    8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd10, 8'd20, 8'd30, 8'd255}});
    rows.push_back('{in_item_t'{OP_APPEND, 17'd256,    8'd200, 8'd150, 8'd100, 9'd256},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd256,    8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd10, 8'd20, 8'd30, 8'd255}});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd300,    8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd10, 8'd20, 8'd30, 8'd255}});
    rows.push_back('{in_item_t'{OP_APPEND, 17'd65536,  8'd255, 8'd0,   8'd255, 9'd0},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd32896,  8'd0,   8'd0,   8'd0,   9'd0},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd257,    8'd0,   8'd0,   8'd0,   9'd0},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd65535,  8'd0,   8'd0,   8'd0,   9'd0},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd65536,  8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd255, 8'd0, 8'd255, 8'd0}});
    rows.push_back('{in_item_t'{OP_QUERY,  17'h1FFFF,  8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd255, 8'd0, 8'd255, 8'd0}});
    rows.push_back('{in_item_t'{OP_APPEND, 17'h1FFFF,  8'd0,   8'd255, 8'd0,   9'h1FF},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd98303,  8'd0,   8'd0,   8'd0,   9'd0},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_CLEAR,  17'd0,      8'd0,   8'd0,   8'd0,   9'd0},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd500,    8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd0, 8'd0, 8'd0, 8'd0}});
    rows.push_back('{in_item_t'{OP_APPEND, 17'd0,      8'd255, 8'd255, 8'd255, 9'd255},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_APPEND, 17'd1,      8'd0,   8'd0,   8'd0,   9'd0},
                     1'b0, out_item_t'('0)});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd0,      8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd255, 8'd255, 8'd255, 8'd255}});
    rows.push_back('{in_item_t'{OP_QUERY,  17'd1,      8'd0,   8'd0,   8'd0,   9'd0},
                     1'b1, out_item_t'{8'd0, 8'd0, 8'd0, 8'd0}});

    // Hold reset, then release it at a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send(rows[i].item, rows[i].fixed, rows[i].want);
    drain();

    // Random ramps: mostly clear, build a ramp, then query it; the rest is raw noise.
    while (taken_cnt < TARGET_ITEMS) begin
      steady_run = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 8) begin
        knob_marks.delete();
        if ($urandom_range(0, 5) != 0) send(rand_item(OP_CLEAR, $urandom_range(0, POS_MAX)));
        pick = $urandom_range(0, 99);
        if (pick < 5)       nk = 0;
        else if (pick < 15) nk = 1;
        else if (pick < 65) nk = $urandom_range(2, 6);
        else if (pick < 88) nk = $urandom_range(7, 16);
        else                nk = $urandom_range(17, 20);   // overfill the table
        // Tiny spacings exercise rounding on short spans; wide ones the long divides.
        case ($urandom_range(0, 3))
          0:       step_max = 3;
          1:       step_max = 255;
          2:       step_max = 4096;
          default: step_max = 16384;
        endcase
        pos = $urandom_range(0, 4 * step_max);
        for (j = 0; j < nk; j++) begin
          if ($urandom_range(0, 15) == 0)
            send(rand_item(OP_SPARE, $urandom_range(0, POS_MAX)));
          if (j > 0 && pos > 0 && $urandom_range(0, 11) == 0)
            send(rand_item(OP_APPEND, $urandom_range(0, pos - 1)));   // goes backwards
          send(rand_item(OP_APPEND, pos));
          knob_marks.push_back(POS_W'(pos));
          pos = pos + $urandom_range(0, step_max);
          if (pos > POS_MAX) pos = POS_MAX;
        end
        nq = $urandom_range(3, 12);
        for (j = 0; j < nq; j++) send(rand_item(OP_QUERY, pick_query()));
      end else begin
        repeat ($urandom_range(3, 10))
          send(rand_item(2'($urandom_range(0, 3)), $urandom_range(0, POS_MAX)));
      end
      if ($urandom_range(0, 7) == 0) drain();
    end

    // Drop start, collect what is owed, then watch for stray results.
    @(negedge clk);
    start <= 1'b0;
    j = 0;
    while (colour_due.size() != 0 && j < DRAIN_LIMIT) begin
      @(negedge clk);
      j++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (colour_due.size() != 0)
      report_mismatch($sformatf("%0d queries never answered", colour_due.size()));
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
